// ----- rtl/core/tsfu_pkg.sv -----
// Shared constants, codes and command/status types of the Taylor-series function unit.
package tsfu_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int FRAC_BITS  = 27;
    localparam int MODE_W     = 4;
    localparam int XW         = 32;
    localparam int OW         = 56;
    localparam int CFG_W      = 5;
    localparam int STAT_W     = 2;
    localparam int TERM_RESET = 8;

    // term magnitude width (cap is all ones)
    localparam int TW  = 62;
    // multiplier operand width: holds |x|, x*x and the small integer factor
    localparam int MW  = (2 * XW - FRAC_BITS + 1 > XW) ? 2 * XW - FRAC_BITS + 1 : XW;
    localparam int PW  = TW + MW;
    localparam int AW  = TW + 2;
    localparam int NW  = $clog2(MAX_TERMS + 1);
    localparam int KW  = $clog2(2 * MAX_TERMS);
    localparam int DW  = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
    localparam int MCW = $clog2(MW);
    localparam int DCW = $clog2(TW);

    localparam logic [TW-1:0] TERM_CAP  = '1;
    localparam logic [TW-1:0] ONE_T     = TW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] OUT_MAX_U = (AW'(1) << (OW - 1)) - AW'(1);
    localparam logic [AW-1:0] OUT_MIN_U = ~OUT_MAX_U;

    typedef enum logic [MODE_W-1:0] {
        MODE_EXP   = 4'd0,
        MODE_LN1P  = 4'd1,
        MODE_SIN   = 4'd2,
        MODE_COS   = 4'd3,
        MODE_ASIN  = 4'd4,
        MODE_ATAN  = 4'd5,
        MODE_COSH  = 4'd6,
        MODE_SINH  = 4'd7,
        MODE_ASINH = 4'd8
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2,
        ST_MODE  = 2'd3
    } t_status;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MS_XX  = 2'd0,
        MS_TX  = 2'd1,
        MS_TX2 = 2'd2,
        MS_TK  = 2'd3
    } t_msel;

    typedef struct packed {
        logic            load;
        logic            mul_go;
        t_msel           msel;
        logic [KW-1:0]   k;
        logic            div_go;
        logic            div_to_term;
        logic [DW-1:0]   divisor;
        logic            t_init;
        logic            t_one;
        logic            acc;
        logic            acc_term;
        logic            acc_flip;
        logic            t_negate;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic x_big;
        logic sat;
    } t_dp_stat;

endpackage

// ----- rtl/core/tsfu_if.sv -----
// Valid/ready channel interfaces for the input and result items.
interface tsfu_in_if;
    logic                                valid;
    logic                                ready;
    logic [tsfu_pkg::MODE_W-1:0]         mode;
    logic signed [tsfu_pkg::XW-1:0]      x_value;

    modport source (output valid, output mode, output x_value, input ready);
    modport sink   (input valid, input mode, input x_value, output ready);
endinterface

interface tsfu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsfu_pkg::OW-1:0]      approx;
    logic [tsfu_pkg::STAT_W-1:0]         status;

    modport source (output valid, output approx, output status, input ready);
    modport sink   (input valid, input approx, input status, output ready);
endinterface

// ----- rtl/core/tsfu_datapath.sv -----
// Datapath: argument and term registers, shift-add multiplier, restoring divider, saturating sum.
module tsfu_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tsfu_pkg::t_cmd                  i_cmd,
    input  logic signed [tsfu_pkg::XW-1:0]  i_x,
    output tsfu_pkg::t_dp_stat              o_stat,
    output logic signed [tsfu_pkg::OW-1:0]  o_sum
);

    logic                           r_x_neg;
    logic [tsfu_pkg::XW-1:0]        r_x_mag;
    logic [tsfu_pkg::MW-1:0]        r_x2;
    logic                           r_t_neg;
    logic [tsfu_pkg::TW-1:0]        r_t_mag;
    logic                           r_term_neg;
    logic [tsfu_pkg::TW-1:0]        r_term_mag;
    logic signed [tsfu_pkg::OW-1:0] r_sum;
    logic                           r_sat;

    // multiplier
    logic                           r_mbusy;
    logic [tsfu_pkg::MCW-1:0]       r_mcnt;
    logic [tsfu_pkg::PW-1:0]        r_ma;
    logic [tsfu_pkg::MW-1:0]        r_mb;
    logic [tsfu_pkg::PW-1:0]        r_mp;
    logic                           r_mint;
    logic                           r_mneg;
    logic                           r_mdst_x2;

    // divider
    logic                           r_dbusy;
    logic [tsfu_pkg::DCW-1:0]       r_dcnt;
    logic [tsfu_pkg::TW-1:0]        r_dq;
    logic [tsfu_pkg::DW-1:0]        r_drem;
    logic [tsfu_pkg::DW-1:0]        r_dd;
    logic                           r_dto_term;

    logic [tsfu_pkg::TW-1:0]        mul_a;
    logic [tsfu_pkg::MW-1:0]        mul_b;
    logic [tsfu_pkg::PW-1:0]        m_add;
    logic [tsfu_pkg::PW-1:0]        m_q;
    logic                           m_last;
    logic                           m_over;
    logic [tsfu_pkg::TW-1:0]        m_res;

    logic [tsfu_pkg::DW:0]          d_sh;
    logic                           d_ge;
    logic [tsfu_pkg::DW:0]          d_sub;
    logic [tsfu_pkg::DW-1:0]        d_rem_nx;
    logic [tsfu_pkg::TW-1:0]        d_q_nx;
    logic                           d_last;

    logic [tsfu_pkg::XW-1:0]        x_mag_in;
    logic                           a_neg;
    logic [tsfu_pkg::TW-1:0]        a_mag;
    logic [tsfu_pkg::AW-1:0]        a_ext;
    logic [tsfu_pkg::AW-1:0]        a_val;
    logic [tsfu_pkg::AW-1:0]        a_sum;
    logic [tsfu_pkg::AW-1:0]        a_s;
    logic                           a_hi;
    logic                           a_lo;

    always_comb begin
        case (i_cmd.msel)
            tsfu_pkg::MS_XX: begin
                mul_a = tsfu_pkg::TW'(r_x_mag);
                mul_b = tsfu_pkg::MW'(r_x_mag);
            end
            tsfu_pkg::MS_TX: begin
                mul_a = r_t_mag;
                mul_b = tsfu_pkg::MW'(r_x_mag);
            end
            tsfu_pkg::MS_TX2: begin
                mul_a = r_t_mag;
                mul_b = r_x2;
            end
            default: begin
                mul_a = r_t_mag;
                mul_b = tsfu_pkg::MW'(i_cmd.k);
            end
        endcase
    end

    // last shift-add step folds into the scaling and the cap check
    assign m_add  = r_mb[0] ? r_mp + r_ma : r_mp;
    assign m_last = (r_mcnt == tsfu_pkg::MCW'(tsfu_pkg::MW - 1));
    assign m_q    = r_mint ? m_add : (m_add >> tsfu_pkg::FRAC_BITS);
    assign m_over = |m_q[tsfu_pkg::PW-1:tsfu_pkg::TW];
    assign m_res  = m_over ? tsfu_pkg::TERM_CAP : m_q[tsfu_pkg::TW-1:0];

    assign d_sh     = {r_drem, r_dq[tsfu_pkg::TW-1]};
    assign d_ge     = (d_sh >= {1'b0, r_dd});
    assign d_sub    = d_sh - {1'b0, r_dd};
    assign d_rem_nx = d_ge ? d_sub[tsfu_pkg::DW-1:0] : d_sh[tsfu_pkg::DW-1:0];
    assign d_q_nx   = {r_dq[tsfu_pkg::TW-2:0], d_ge};
    assign d_last   = (r_dcnt == tsfu_pkg::DCW'(tsfu_pkg::TW - 1));

    assign x_mag_in = i_x[tsfu_pkg::XW-1] ? (~i_x + 1'b1) : i_x;

    assign a_neg = (i_cmd.acc_term ? r_term_neg : r_t_neg) ^ i_cmd.acc_flip;
    assign a_mag = i_cmd.acc_term ? r_term_mag : r_t_mag;
    assign a_ext = {2'b00, a_mag};
    assign a_val = a_neg ? (~a_ext + 1'b1) : a_ext;
    assign a_sum = {{(tsfu_pkg::AW - tsfu_pkg::OW){r_sum[tsfu_pkg::OW-1]}}, r_sum} + a_val;
    assign a_hi  = $signed(a_sum) > $signed(tsfu_pkg::OUT_MAX_U);
    assign a_lo  = $signed(a_sum) < $signed(tsfu_pkg::OUT_MIN_U);
    assign a_s   = a_hi ? tsfu_pkg::OUT_MAX_U : (a_lo ? tsfu_pkg::OUT_MIN_U : a_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_cmd.mul_go) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (m_last) begin
                    r_mbusy <= 1'b0;
                end
            end
            if (i_cmd.div_go) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
                if (d_last) begin
                    r_dbusy <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_sat <= 1'b0;
            end else if ((r_mbusy && m_last && m_over) || (i_cmd.acc && (a_hi || a_lo))) begin
                r_sat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_neg <= i_x[tsfu_pkg::XW-1];
            r_x_mag <= x_mag_in;
            r_sum   <= '0;
        end
        if (i_cmd.mul_go) begin
            r_ma      <= tsfu_pkg::PW'(mul_a);
            r_mb      <= mul_b;
            r_mp      <= '0;
            r_mint    <= (i_cmd.msel == tsfu_pkg::MS_TK);
            r_mneg    <= r_t_neg ^ ((i_cmd.msel == tsfu_pkg::MS_TX) && r_x_neg);
            r_mdst_x2 <= (i_cmd.msel == tsfu_pkg::MS_XX);
        end else if (r_mbusy) begin
            r_mp <= m_add;
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
            if (m_last) begin
                if (r_mdst_x2) begin
                    r_x2 <= m_res[tsfu_pkg::MW-1:0];
                end else begin
                    r_t_neg <= r_mneg;
                    r_t_mag <= m_res;
                end
            end
        end
        if (i_cmd.div_go) begin
            r_dq       <= r_t_mag;
            r_drem     <= '0;
            r_dd       <= i_cmd.divisor;
            r_dto_term <= i_cmd.div_to_term;
        end else if (r_dbusy) begin
            r_dq   <= d_q_nx;
            r_drem <= d_rem_nx;
            if (d_last) begin
                if (r_dto_term) begin
                    r_term_neg <= r_t_neg;
                    r_term_mag <= d_q_nx;
                end else begin
                    r_t_mag <= d_q_nx;
                end
            end
        end
        if (i_cmd.t_init) begin
            r_t_neg <= i_cmd.t_one ? 1'b0 : r_x_neg;
            r_t_mag <= i_cmd.t_one ? tsfu_pkg::ONE_T : tsfu_pkg::TW'(r_x_mag);
        end
        if (i_cmd.acc) begin
            r_sum <= a_s[tsfu_pkg::OW-1:0];
            if (i_cmd.t_negate) begin
                r_t_neg <= ~r_t_neg;
            end
        end
    end

    assign o_stat.mul_done = r_mbusy && m_last;
    assign o_stat.div_done = r_dbusy && d_last;
    assign o_stat.x_big    = tsfu_pkg::TW'(r_x_mag) > tsfu_pkg::ONE_T;
    assign o_stat.sat      = r_sat;
    assign o_sum           = r_sum;

endmodule

// ----- rtl/core/tsfu_ctrl.sv -----
// Controller: term_count register and the sequencer that steps the series through the datapath.
module tsfu_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [tsfu_pkg::MODE_W-1:0]       i_mode,
    input  logic                              i_cfg_we,
    input  logic [tsfu_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  tsfu_pkg::t_dp_stat                i_stat,
    input  logic                              i_out_free,
    output tsfu_pkg::t_cmd                    o_cmd,
    output logic                              o_out_wr,
    output tsfu_pkg::t_status                 o_out_code
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CHECK   = 9'b000000010,
        S_X2      = 9'b000000100,
        S_INIT    = 9'b000001000,
        S_MUL     = 9'b000010000,
        S_MULI    = 9'b000100000,
        S_DIVT    = 9'b001000000,
        S_DIVTERM = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    // S_ACC folded: one more code would be needed, so it is a separate phase register below
    typedef enum logic [1:0] {
        P_RUN = 2'b01,
        P_ACC = 2'b10
    } t_phase;

    t_state                      r_state, n_state;
    t_phase                      r_phase, n_phase;
    logic                        r_started, n_started;
    logic [tsfu_pkg::NW-1:0]     r_n, n_n;
    logic [tsfu_pkg::MODE_W-1:0] r_mode, n_mode;
    tsfu_pkg::t_status           r_code, n_code;
    logic [tsfu_pkg::CFG_W-1:0]  r_tc;

    logic [tsfu_pkg::NW-1:0]     m_eff;
    logic                        is_exp, is_ln1p, is_sin, is_cos, is_asin;
    logic                        is_atan, is_cosh, is_sinh, is_asinh;
    logic                        asin_fam, has_divt, has_divterm, use_x, init_one, restricted;
    logic [tsfu_pkg::DW-1:0]     n_ext, two_n, div_t, div_term;
    t_state                      after_mul, after_divt;

    always_comb begin
        if (r_tc == '0) begin
            m_eff = tsfu_pkg::NW'(1);
        end else if (int'(r_tc) > tsfu_pkg::MAX_TERMS) begin
            m_eff = tsfu_pkg::NW'(tsfu_pkg::MAX_TERMS);
        end else begin
            m_eff = tsfu_pkg::NW'(r_tc);
        end
    end

    assign is_exp   = (r_mode == tsfu_pkg::MODE_EXP);
    assign is_ln1p  = (r_mode == tsfu_pkg::MODE_LN1P);
    assign is_sin   = (r_mode == tsfu_pkg::MODE_SIN);
    assign is_cos   = (r_mode == tsfu_pkg::MODE_COS);
    assign is_asin  = (r_mode == tsfu_pkg::MODE_ASIN);
    assign is_atan  = (r_mode == tsfu_pkg::MODE_ATAN);
    assign is_cosh  = (r_mode == tsfu_pkg::MODE_COSH);
    assign is_sinh  = (r_mode == tsfu_pkg::MODE_SINH);
    assign is_asinh = (r_mode == tsfu_pkg::MODE_ASINH);

    assign asin_fam    = is_asin || is_asinh;
    assign has_divt    = is_exp || is_sin || is_cos || is_cosh || is_sinh || asin_fam;
    assign has_divterm = is_ln1p || is_atan || asin_fam;
    assign use_x       = is_exp || is_ln1p;
    assign init_one    = is_exp || is_cos || is_cosh;
    assign restricted  = is_ln1p || asin_fam || is_atan;

    assign n_ext = tsfu_pkg::DW'(r_n);
    assign two_n = n_ext << 1;

    always_comb begin
        if (is_exp) begin
            div_t = n_ext;
        end else if (is_sin || is_sinh) begin
            div_t = two_n * (two_n + 1'b1);
        end else if (is_cos || is_cosh) begin
            div_t = (two_n - 1'b1) * two_n;
        end else begin
            div_t = two_n;
        end
        div_term = is_ln1p ? n_ext : two_n + 1'b1;
    end

    assign after_mul  = asin_fam ? S_MULI : (has_divt ? S_DIVT :
                        (has_divterm ? S_DIVTERM : S_IDLE));
    assign after_divt = has_divterm ? S_DIVTERM : S_IDLE;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_started  = r_started;
        n_n        = r_n;
        n_mode     = r_mode;
        n_code     = r_code;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_wr   = 1'b0;

        if (r_phase == P_ACC) begin
            // add t or the divided term into the sum, then advance n or finish after the last term
            o_cmd.acc = 1'b1;
            n_phase   = P_RUN;
            n_started = 1'b0;
            if (r_n == '0) begin
                n_n     = tsfu_pkg::NW'(1);
                n_state = S_MUL;
            end else begin
                o_cmd.acc_term = has_divterm;
                o_cmd.t_negate = is_sin || is_cos;
                o_cmd.acc_flip = is_sin || is_cos || (is_ln1p && !r_n[0]) ||
                                 ((is_atan || is_asinh) && r_n[0]);
                if (r_n == m_eff) begin
                    n_state = S_DONE;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_state = S_MUL;
                end
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_mode     = i_mode;
                        n_state    = S_CHECK;
                    end
                end
                S_CHECK: begin
                    n_started = 1'b0;
                    if (r_mode > tsfu_pkg::MODE_ASINH) begin
                        n_code  = tsfu_pkg::ST_MODE;
                        n_state = S_DONE;
                    end else if (restricted && i_stat.x_big) begin
                        n_code  = tsfu_pkg::ST_RANGE;
                        n_state = S_DONE;
                    end else begin
                        n_code  = tsfu_pkg::ST_OK;
                        n_state = S_X2;
                    end
                end
                S_X2: begin
                    if (!r_started) begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.msel   = tsfu_pkg::MS_XX;
                        n_started    = 1'b1;
                    end else if (i_stat.mul_done) begin
                        n_started = 1'b0;
                        n_state   = S_INIT;
                    end
                end
                S_INIT: begin
                    o_cmd.t_init = 1'b1;
                    o_cmd.t_one  = init_one;
                    if (is_ln1p) begin
                        // ln1p starts at n = 1 with t = x and no multiply
                        n_n     = tsfu_pkg::NW'(1);
                        n_state = S_DIVTERM;
                    end else begin
                        n_n     = '0;
                        n_phase = P_ACC;
                    end
                end
                S_MUL: begin
                    if (is_ln1p && r_n == tsfu_pkg::NW'(1)) begin
                        n_state = S_DIVTERM;
                    end else if (!r_started) begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.msel   = use_x ? tsfu_pkg::MS_TX : tsfu_pkg::MS_TX2;
                        n_started    = 1'b1;
                    end else if (i_stat.mul_done) begin
                        n_started = 1'b0;
                        if (after_mul == S_IDLE) begin
                            n_phase = P_ACC;
                        end else begin
                            n_state = after_mul;
                        end
                    end
                end
                S_MULI: begin
                    if (!r_started) begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.msel   = tsfu_pkg::MS_TK;
                        o_cmd.k      = tsfu_pkg::KW'(two_n - 1'b1);
                        n_started    = 1'b1;
                    end else if (i_stat.mul_done) begin
                        n_started = 1'b0;
                        n_state   = S_DIVT;
                    end
                end
                S_DIVT: begin
                    if (!r_started) begin
                        o_cmd.div_go  = 1'b1;
                        o_cmd.divisor = div_t;
                        n_started     = 1'b1;
                    end else if (i_stat.div_done) begin
                        n_started = 1'b0;
                        if (after_divt == S_IDLE) begin
                            n_phase = P_ACC;
                        end else begin
                            n_state = after_divt;
                        end
                    end
                end
                S_DIVTERM: begin
                    if (!r_started) begin
                        o_cmd.div_go      = 1'b1;
                        o_cmd.div_to_term = 1'b1;
                        o_cmd.divisor     = div_term;
                        n_started         = 1'b1;
                    end else if (i_stat.div_done) begin
                        n_started = 1'b0;
                        n_phase   = P_ACC;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        o_out_wr = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    assign o_out_code = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= P_RUN;
            r_started <= 1'b0;
            r_tc      <= tsfu_pkg::CFG_W'(tsfu_pkg::TERM_RESET);
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_started <= n_started;
            if (i_cfg_we) begin
                r_tc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_mode <= n_mode;
        r_code <= n_code;
    end

endmodule

// ----- rtl/core/taylor_series_function_unit.sv -----
// Top level of the Taylor-series function unit: controller, datapath and result register.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    mode[3:0], x_value[31:0] signed Q4.27
//  o_out     out  valid/ready    approx[55:0] signed Q28.27, status[1:0]
//  cfg       in   i_cfg_we       i_cfg_wdata[4:0] = term_count
//
// One item at a time. Setup runs the mode and range check, then x*x on the shift-add
// multiplier; each term then runs its multiply, its divides on the restoring
// divider and an add, and asin/asinh add an integer multiply to each term.
// Invalid modes and out-of-range arguments finish without running the series.
// Reset is synchronous and active low; term_count returns to 8.
// A finished result waits in the output register while the next item is taken;
// a sequencer holds only in its final state while that register is full and not read.
module taylor_series_function_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tsfu_in_if.sink                          i_in,
    tsfu_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [tsfu_pkg::CFG_W-1:0]       i_cfg_wdata
);

    tsfu_pkg::t_cmd                 cmd;
    tsfu_pkg::t_dp_stat             stat;
    tsfu_pkg::t_status              out_code;
    logic signed [tsfu_pkg::OW-1:0] sum;
    logic                           in_ready;
    logic                           out_wr;
    logic                           out_free;

    logic                           r_out_valid;
    logic signed [tsfu_pkg::OW-1:0] r_approx;
    logic [tsfu_pkg::STAT_W-1:0]    r_status;

    assign out_free = !r_out_valid || o_out.ready;

    tsfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_mode      (i_in.mode),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .i_out_free  (out_free),
        .o_cmd       (cmd),
        .o_out_wr    (out_wr),
        .o_out_code  (out_code)
    );

    tsfu_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (i_in.x_value),
        .o_stat  (stat),
        .o_sum   (sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_wr) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            if (out_code == tsfu_pkg::ST_OK) begin
                r_approx <= sum;
                r_status <= stat.sat ? tsfu_pkg::ST_SAT : tsfu_pkg::ST_OK;
            end else begin
                r_approx <= '0;
                r_status <= out_code;
            end
        end
    end

    assign i_in.ready   = in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.approx = r_approx;
    assign o_out.status = r_status;

endmodule
